FILE: hdl/aabb_pkg.sv
// shared types, constants and helpers for the rectangle collision side detector
package aabb_pkg;

  localparam int MAX_OBSTACLES = 16;
  localparam int COORD_BITS    = 16;
  localparam int LEN_BITS      = COORD_BITS - 1;
  localparam int EDGE_BITS     = COORD_BITS + 1;
  localparam int DIFF_BITS     = COORD_BITS + 2;
  localparam int ADDR_BITS     = $clog2(MAX_OBSTACLES);
  localparam int CNT_BITS      = $clog2(MAX_OBSTACLES + 1);
  localparam int SLOT_BITS     = 4;
  localparam int COUNT_BITS    = 5;
  localparam int PADDR_BITS    = 2;
  localparam int PDATA_BITS    = 32;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [LEN_BITS-1:0]          len_t;
  typedef logic signed [EDGE_BITS-1:0]  edge_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [DIFF_BITS-1:0]         mag_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    len_t   width;
    len_t   height;
  } rect_t;

  // per-axis verdict of the shared compare unit
  typedef struct packed {
    logic overlap;
    logic low_side;
    logic high_side;
  } axis_res_t;

  function automatic mag_t mag(input diff_t v);
    mag_t m;
    m = v[DIFF_BITS-1] ? mag_t'(-v) : mag_t'(v);
    return m;
  endfunction

endpackage

FILE: hdl/aabb_ram.sv
// generic single write port ram with registered read
module aabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/aabb_axis_unit.sv
// shared one-axis overlap and side-rule compare unit
module aabb_axis_unit import aabb_pkg::*; (
  input  coord_t    t_lo,
  input  len_t      t_len,
  input  coord_t    o_lo,
  input  len_t      o_len,
  output axis_res_t res
);

  edge_t t_lo_e, o_lo_e, t_len_e, o_len_e, t_hi, o_hi;
  diff_t d_tlo_ohi, d_tlo_olo, d_olo_thi, d_ohi_thi;

  assign t_lo_e  = EDGE_BITS'(t_lo);
  assign o_lo_e  = EDGE_BITS'(o_lo);
  assign t_len_e = EDGE_BITS'(t_len);
  assign o_len_e = EDGE_BITS'(o_len);
  assign t_hi    = t_lo_e + t_len_e;
  assign o_hi    = o_lo_e + o_len_e;

  assign d_tlo_ohi = DIFF_BITS'(t_lo_e) - DIFF_BITS'(o_hi);
  assign d_tlo_olo = DIFF_BITS'(t_lo_e) - DIFF_BITS'(o_lo_e);
  assign d_olo_thi = DIFF_BITS'(o_lo_e) - DIFF_BITS'(t_hi);
  assign d_ohi_thi = DIFF_BITS'(o_hi)   - DIFF_BITS'(t_hi);

  // strict overlap: max of lows below min of highs, zero length never overlaps
  assign res.overlap   = (t_lo_e < o_hi) && (o_lo_e < t_hi) &&
                         (t_len != '0) && (o_len != '0);
  assign res.low_side  = mag(d_tlo_ohi) <= mag(d_tlo_olo);
  assign res.high_side = mag(d_olo_thi) <= mag(d_ohi_thi);

endmodule

FILE: hdl/aabb_collision_side_detector.sv
// sequence: a query steps S_READ, S_XAXIS, S_YAXIS per tested obstacle, then S_DONE; a load leaves the block ready
// concurrency: one query at a time; the table ram read and the one shared axis
// compare unit (x pass, then y pass per obstacle) set the read, x and y steps per obstacle
// the result register lets the next word in while a result waits to be taken
// reset: synchronous, clears sequencer, result valid and obstacle_count; table is not cleared
module aabb_collision_side_detector import aabb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  command,
  input  logic [SLOT_BITS-1:0]  slot,
  input  coord_t                rect_left,
  input  coord_t                rect_top,
  input  len_t                  rect_width,
  input  len_t                  rect_height,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic                  any_hit,
  output logic                  left_hit,
  output logic                  right_hit,
  output logic                  top_hit,
  output logic                  bottom_hit,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_XAXIS,
    S_YAXIS,
    S_DONE
  } state_t;

  state_t              state;
  logic [COUNT_BITS-1:0] obstacle_count;
  logic [CNT_BITS-1:0] idx, limit, limit_next, idx_inc;
  rect_t               target, entry, in_rect;
  logic                in_take, ram_we;
  logic                x_overlap, x_low, x_high;
  logic                acc_any, acc_left, acc_right, acc_top, acc_bottom;
  logic                hit;
  coord_t              t_lo, o_lo;
  len_t                t_len, o_len;
  axis_res_t           axis;

  // config register
  assign pready = 1'b1;
  assign prdata = PDATA_BITS'(obstacle_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_count <= '0;
    end else if (psel && penable && pwrite && (paddr == '0)) begin
      obstacle_count <= pwdata[COUNT_BITS-1:0];
    end
  end

  assign item_ready = (state == S_IDLE);
  assign in_take    = item_valid && item_ready;
  assign in_rect    = '{left: rect_left, top: rect_top, width: rect_width, height: rect_height};
  assign ram_we     = in_take && (command == CMD_LOAD) &&
                      (CNT_BITS'(slot) < CNT_BITS'(MAX_OBSTACLES));

  aabb_ram #(
    .WIDTH ($bits(rect_t)),
    .DEPTH (MAX_OBSTACLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_BITS'(slot)),
    .wdata (in_rect),
    .raddr (idx[ADDR_BITS-1:0]),
    .rdata (entry)
  );

  // x pass in S_XAXIS, y pass otherwise
  always_comb begin
    if (state == S_XAXIS) begin
      t_lo  = target.left;
      t_len = target.width;
      o_lo  = entry.left;
      o_len = entry.width;
    end else begin
      t_lo  = target.top;
      t_len = target.height;
      o_lo  = entry.top;
      o_len = entry.height;
    end
  end

  aabb_axis_unit u_axis (
    .t_lo  (t_lo),
    .t_len (t_len),
    .o_lo  (o_lo),
    .o_len (o_len),
    .res   (axis)
  );

  assign hit        = x_overlap && axis.overlap;
  assign idx_inc    = idx + CNT_BITS'(1);
  assign limit_next = (obstacle_count > COUNT_BITS'(MAX_OBSTACLES)) ?
                      CNT_BITS'(MAX_OBSTACLES) : CNT_BITS'(obstacle_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // in S_DONE the result register is handled by the state itself
      if (result_valid && result_ready && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take && (command == CMD_QUERY)) begin
            target     <= in_rect;
            limit      <= limit_next;
            idx        <= '0;
            acc_any    <= 1'b0;
            acc_left   <= 1'b0;
            acc_right  <= 1'b0;
            acc_top    <= 1'b0;
            acc_bottom <= 1'b0;
            state      <= (limit_next == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          state <= S_XAXIS;
        end
        S_XAXIS: begin
          x_overlap <= axis.overlap;
          x_low     <= axis.low_side;
          x_high    <= axis.high_side;
          state     <= S_YAXIS;
        end
        S_YAXIS: begin
          acc_any    <= acc_any    | hit;
          acc_left   <= acc_left   | (hit && x_low);
          acc_right  <= acc_right  | (hit && x_high);
          acc_top    <= acc_top    | (hit && axis.low_side);
          acc_bottom <= acc_bottom | (hit && axis.high_side);
          idx        <= idx_inc;
          state      <= (idx_inc == limit) ? S_DONE : S_READ;
        end
        S_DONE: begin
          // wait for the result register to be free
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            any_hit      <= acc_any;
            left_hit     <= acc_left;
            right_hit    <= acc_right;
            top_hit      <= acc_top;
            bottom_hit   <= acc_bottom;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/aabb_checker.sv
// port-level checks for the rectangle collision side detector, bound to the top level
module aabb_checker import aabb_pkg::*; (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input logic command,
  input logic result_valid,
  input logic result_ready,
  input logic any_hit,
  input logic left_hit,
  input logic right_hit,
  input logic top_hit,
  input logic bottom_hit
);

  // a waiting result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(any_hit) &&
    $stable(left_hit) && $stable(right_hit) && $stable(top_hit) && $stable(bottom_hit))
    else $error("result word changed while stalled");

  // a side flag needs an overlap
  a_side_needs_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid && (left_hit || right_hit || top_hit || bottom_hit) |-> any_hit)
    else $error("side flag without overlap");

  // a query keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (command == CMD_QUERY) |=> !item_ready)
    else $error("ready right after a query");

  // a load leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (command == CMD_LOAD) |=> item_ready)
    else $error("load made the block busy");

  // no result appears the cycle after a query is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (command == CMD_QUERY) |=> !$rose(result_valid))
    else $error("result too early");

endmodule

bind aabb_collision_side_detector aabb_checker u_aabb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .command      (command),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .any_hit      (any_hit),
  .left_hit     (left_hit),
  .right_hit    (right_hit),
  .top_hit      (top_hit),
  .bottom_hit   (bottom_hit)
);
